// ===== src/pcf_pkg.sv =====
// Shared types and constants for the palette color fader.
// No dependencies; used by pcf_lerp and palette_color_fader.
package pcf_pkg;

    // command codes carried on s_cmd
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_LOAD    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_FADE_STEPS   = 2'd0;
    localparam logic [1:0] REG_PALETTE_SIZE = 2'd1;
    localparam logic [1:0] REG_FADE_MODE    = 2'd2;

    localparam int         CFG_DATA_W       = 8;
    localparam logic [7:0] FADE_STEPS_RESET = 8'd50;

    // request to the shared interpolation unit
    typedef struct packed {
        logic        start;
        logic [23:0] src_color;
        logic [23:0] dst_color;
        logic [7:0]  step;
        logic [7:0]  total;
    } lerp_req_t;

    // response from the shared interpolation unit
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [23:0] color;
    } lerp_rsp_t;

endpackage

// ===== src/palette_color_fader.sv =====
// Palette color fader top level: sequencer, palette memory, state and
// output register. Depends on pcf_pkg and pcf_lerp.
//
// Usage:
//   Input channel s_* (valid/ready) takes one command per transaction:
//   tick, load palette entry, or restart. Result channel m_* (valid/ready)
//   carries one color per tick while palette_size is nonzero; load and
//   restart give no result. Configuration (cfg_*) is written one register
//   per cycle with cfg_wr_en; the user must write it only while the block
//   is idle, since the block itself does not enforce it.
// Operation, from the accepting edge: load writes the memory at that edge;
//   restart makes two palette reads through the registered memory port;
//   step-mode tick reads one palette entry; fade-mode tick first reads the
//   next entry when the fade moves on, then runs the shared multiply /
//   8-step restoring divide unit on each color channel in turn.
//   s_ready is high only while the sequencer is idle.
// Reset (aresetn low, synchronous): fade_steps 50, palette_size 0,
//   fade_mode 0, indices and fade colors cleared, target index 1. Palette
//   contents are not cleared and must be loaded before use.
// Stall: the result sits in the output register; the block accepts the
//   next transaction meanwhile and waits only if a new color is ready
//   before the previous one is taken.
module palette_color_fader #(
    parameter int PALETTE_DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [1:0]                     cfg_index,
    input  logic [pcf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // command channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_cmd,
    input  logic [3:0]                     s_entry_index,
    input  logic [23:0]                    s_entry_color,
    // color channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_red,
    output logic [7:0]                     m_green,
    output logic [7:0]                     m_blue,
    output logic [3:0]                     m_color_index
);

    localparam int IW = $clog2(PALETTE_DEPTH);
    localparam int CW = ((IW > 5) ? IW : 5) + 1;   // holds depth and size
    localparam logic [CW-1:0] DEPTH_C = CW'(PALETTE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RST_W0,
        S_RST_U0,
        S_RST_W1,
        S_RST_U1,
        S_ST_W,
        S_ST_U,
        S_FD_W,
        S_FD_U,
        S_FD_GO,
        S_FD_RUN,
        S_FD_OUT
    } state_t;

    // palette memory, one write and one registered read port
    logic [23:0] palette_mem [PALETTE_DEPTH];
    logic          mem_we;
    logic [IW-1:0] mem_waddr;

    state_t        state_reg,        state_next;
    logic [7:0]    fade_steps_reg,   fade_steps_next;
    logic [4:0]    palette_size_reg, palette_size_next;
    logic          fade_mode_reg,    fade_mode_next;
    logic [23:0]   fade_start_reg,   fade_start_next;
    logic [23:0]   fade_target_reg,  fade_target_next;
    logic [7:0]    step_count_reg,   step_count_next;
    logic [IW-1:0] target_index_reg, target_index_next;
    logic [IW-1:0] step_index_reg,   step_index_next;
    logic [IW-1:0] rd_addr_reg,      rd_addr_next;
    logic [23:0]   rd_data_reg;
    logic          out_valid_reg,    out_valid_next;
    logic [23:0]   out_color_reg,    out_color_next;
    logic [3:0]    out_index_reg,    out_index_next;

    logic [CW-1:0] size;
    logic [7:0]    total;
    logic          out_free;
    logic [IW-1:0] step_i;
    logic [IW-1:0] adv_target;

    pcf_pkg::lerp_req_t lerp_req;
    pcf_pkg::lerp_rsp_t lerp_rsp;

    // index past the size in use wraps to zero
    function automatic logic [IW-1:0] wrap_idx(input logic [IW-1:0] i,
                                               input logic [CW-1:0] sz);
        return (CW'(i) >= sz) ? '0 : i;
    endfunction

    function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i,
                                               input logic [CW-1:0] sz);
        logic [CW-1:0] n;
        n = CW'(i) + CW'(1);
        return (n >= sz) ? '0 : n[IW-1:0];
    endfunction

    assign size       = (CW'(palette_size_reg) > DEPTH_C) ? DEPTH_C
                                                          : CW'(palette_size_reg);
    assign total      = (fade_steps_reg == 8'd0) ? 8'd1 : fade_steps_reg;
    assign out_free   = !out_valid_reg || m_ready;
    assign step_i     = wrap_idx(step_index_reg, size);
    assign adv_target = next_idx(wrap_idx(target_index_reg, size), size);

    assign lerp_req.start     = (state_reg == S_FD_GO);
    assign lerp_req.src_color = fade_start_reg;
    assign lerp_req.dst_color = fade_target_reg;
    assign lerp_req.step      = step_count_reg;
    assign lerp_req.total     = total;

    pcf_lerp u_lerp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (lerp_req),
        .rsp     (lerp_rsp)
    );

    // loads land at the accepting edge; out-of-range indexes are dropped
    assign mem_we    = s_valid && s_ready && (s_cmd == pcf_pkg::CMD_LOAD)
                       && (CW'(s_entry_index) < DEPTH_C);
    assign mem_waddr = IW'(s_entry_index);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            palette_mem[mem_waddr] <= s_entry_color;
        end
        rd_data_reg <= palette_mem[rd_addr_reg];
    end

    always_comb begin
        state_next        = state_reg;
        fade_steps_next   = fade_steps_reg;
        palette_size_next = palette_size_reg;
        fade_mode_next    = fade_mode_reg;
        fade_start_next   = fade_start_reg;
        fade_target_next  = fade_target_reg;
        step_count_next   = step_count_reg;
        target_index_next = target_index_reg;
        step_index_next   = step_index_reg;
        rd_addr_next      = rd_addr_reg;
        out_valid_next    = out_valid_reg && !m_ready;
        out_color_next    = out_color_reg;
        out_index_next    = out_index_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                pcf_pkg::REG_FADE_STEPS:   fade_steps_next   = cfg_wdata[7:0];
                pcf_pkg::REG_PALETTE_SIZE: palette_size_next = cfg_wdata[4:0];
                pcf_pkg::REG_FADE_MODE:    fade_mode_next    = cfg_wdata[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (s_cmd)
                        pcf_pkg::CMD_RESTART: begin
                            step_count_next = 8'd0;
                            step_index_next = '0;
                            if (size == '0) begin
                                target_index_next = '0;
                                fade_start_next   = 24'd0;
                                fade_target_next  = 24'd0;
                            end else begin
                                target_index_next = (size == CW'(1)) ? '0 : IW'(1);
                                rd_addr_next      = '0;
                                state_next        = S_RST_W0;
                            end
                        end
                        pcf_pkg::CMD_TICK: begin
                            if (size != '0) begin
                                if (!fade_mode_reg) begin
                                    rd_addr_next    = step_i;
                                    step_index_next = next_idx(step_i, size);
                                    state_next      = S_ST_W;
                                end else if (step_count_reg >= total) begin
                                    // current fade done: move on to the next entry
                                    step_count_next   = 8'd0;
                                    target_index_next = adv_target;
                                    fade_start_next   = fade_target_reg;
                                    rd_addr_next      = adv_target;
                                    state_next        = S_FD_W;
                                end else begin
                                    state_next = S_FD_GO;
                                end
                            end
                        end
                        default: ;   // load handled at the memory, unused code ignored
                    endcase
                end
            end
            S_RST_W0: state_next = S_RST_U0;
            S_RST_U0: begin
                fade_start_next = rd_data_reg;
                rd_addr_next    = target_index_reg;
                state_next      = S_RST_W1;
            end
            S_RST_W1: state_next = S_RST_U1;
            S_RST_U1: begin
                fade_target_next = rd_data_reg;
                state_next       = S_IDLE;
            end
            S_ST_W: state_next = S_ST_U;
            S_ST_U: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_color_next = rd_data_reg;
                    out_index_next = 4'(rd_addr_reg);
                    state_next     = S_IDLE;
                end
            end
            S_FD_W: state_next = S_FD_U;
            S_FD_U: begin
                fade_target_next = rd_data_reg;
                state_next       = S_FD_GO;
            end
            S_FD_GO: state_next = S_FD_RUN;
            S_FD_RUN: begin
                if (lerp_rsp.done) begin
                    state_next = S_FD_OUT;
                end
            end
            S_FD_OUT: begin
                if (out_free && !lerp_rsp.busy) begin
                    out_valid_next  = 1'b1;
                    out_color_next  = lerp_rsp.color;
                    out_index_next  = 4'(target_index_reg);
                    step_count_next = step_count_reg + 8'd1;
                    state_next      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            fade_steps_reg   <= pcf_pkg::FADE_STEPS_RESET;
            palette_size_reg <= 5'd0;
            fade_mode_reg    <= 1'b0;
            fade_start_reg   <= 24'd0;
            fade_target_reg  <= 24'd0;
            step_count_reg   <= 8'd0;
            target_index_reg <= IW'(1);
            step_index_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            fade_steps_reg   <= fade_steps_next;
            palette_size_reg <= palette_size_next;
            fade_mode_reg    <= fade_mode_next;
            fade_start_reg   <= fade_start_next;
            fade_target_reg  <= fade_target_next;
            step_count_reg   <= step_count_next;
            target_index_reg <= target_index_next;
            step_index_reg   <= step_index_next;
            out_valid_reg    <= out_valid_next;
        end
        // payload registers, no reset
        rd_addr_reg   <= rd_addr_next;
        out_color_reg <= out_color_next;
        out_index_reg <= out_index_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = out_valid_reg;
    assign m_red         = out_color_reg[23:16];
    assign m_green       = out_color_reg[15:8];
    assign m_blue        = out_color_reg[7:0];
    assign m_color_index = out_index_reg;

endmodule

// ===== src/pcf_lerp.sv =====
// Shared interpolation unit: src + (dst - src) * step / total for the three
// color channels, one channel at a time. Depends on pcf_pkg.
module pcf_lerp (
    input  logic              aclk,
    input  logic              aresetn,
    input  pcf_pkg::lerp_req_t req,
    output pcf_pkg::lerp_rsp_t rsp
);

    typedef enum logic [1:0] {
        L_IDLE,
        L_MUL,
        L_DIV,
        L_ADD
    } lerp_state_t;

    lerp_state_t state_reg;
    logic [1:0]  chan_reg;
    logic [2:0]  cnt_reg;
    logic [7:0]  rem_reg;
    logic [7:0]  lo_reg;
    logic [7:0]  quo_reg;
    logic        neg_reg;
    logic        done_reg;
    logic [23:0] src_reg;
    logic [23:0] dst_reg;
    logic [7:0]  step_reg;
    logic [7:0]  total_reg;
    logic [23:0] color_reg;

    logic [4:0]  lsb;
    logic [7:0]  s_ch;
    logic [7:0]  t_ch;
    logic [8:0]  diff;
    logic [7:0]  mag;
    logic [15:0] prod;
    logic [8:0]  trial;
    logic [7:0]  trial_sub;
    logic        ge;
    logic [7:0]  delta;

    assign lsb   = {chan_reg, 3'b000};
    assign s_ch  = src_reg[lsb +: 8];
    assign t_ch  = dst_reg[lsb +: 8];
    assign diff  = {1'b0, t_ch} - {1'b0, s_ch};
    assign mag   = diff[8] ? 8'(~diff + 9'd1) : diff[7:0];
    assign prod  = 16'(mag) * 16'(step_reg);

    // restoring divide step; quotient fits 8 bits since step < total
    assign trial     = {rem_reg, lo_reg[7]};
    assign trial_sub = 8'(trial - {1'b0, total_reg});
    assign ge        = trial >= {1'b0, total_reg};
    assign delta     = neg_reg ? 8'(~quo_reg + 8'd1) : quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
            chan_reg  <= 2'd0;
            cnt_reg   <= 3'd0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE: begin
                    if (req.start) begin
                        src_reg   <= req.src_color;
                        dst_reg   <= req.dst_color;
                        step_reg  <= req.step;
                        total_reg <= req.total;
                        chan_reg  <= 2'd0;
                        state_reg <= L_MUL;
                    end
                end
                L_MUL: begin
                    rem_reg   <= prod[15:8];
                    lo_reg    <= prod[7:0];
                    neg_reg   <= diff[8];
                    quo_reg   <= 8'd0;
                    cnt_reg   <= 3'd0;
                    state_reg <= L_DIV;
                end
                L_DIV: begin
                    rem_reg <= ge ? trial_sub : trial[7:0];
                    quo_reg <= {quo_reg[6:0], ge};
                    lo_reg  <= {lo_reg[6:0], 1'b0};
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7) begin
                        state_reg <= L_ADD;
                    end
                end
                L_ADD: begin
                    color_reg[lsb +: 8] <= s_ch + delta;
                    if (chan_reg == 2'd2) begin
                        done_reg  <= 1'b1;
                        state_reg <= L_IDLE;
                    end else begin
                        chan_reg  <= chan_reg + 2'd1;
                        state_reg <= L_MUL;
                    end
                end
            endcase
        end
    end

    assign rsp.busy  = (state_reg != L_IDLE);
    assign rsp.done  = done_reg;
    assign rsp.color = color_reg;

endmodule

// ===== tb/palette_color_fader_tb.sv =====
// Self-checking testbench for palette_color_fader: directed and random command
// streams with a built-in color predictor and per-field result checks.
// Depends on pcf_pkg and the palette_color_fader RTL only.
`timescale 1ns / 100ps

module palette_color_fader_tb;

    localparam int PAL_DEPTH     = 16;
    localparam int SETTLE_CYCLES = 60;      // exceeds the slowest fade tick
    localparam int DRAIN_LIMIT   = 20000;   // cycles to wait for results to drain
    localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
    localparam int PHASE_ITEMS   = 100;     // transactions per random phase
    localparam int PHASE_COUNT   = 12;

    // command code the block ignores
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // receiver m_ready behavior
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_RUNS
    } ready_style_t;

    // one color transaction on the m_* channel
    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [3:0] index;
    } color_result_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [1:0]  cfg_index     = pcf_pkg::REG_FADE_STEPS;
    logic [7:0]  cfg_wdata     = '0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd         = pcf_pkg::CMD_TICK;
    logic [3:0]  s_entry_index = '0;
    logic [23:0] s_entry_color = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;
    logic [3:0]  m_color_index;

    // ------------------------------------------------------------------
    // Predictor state: palette copy, fade state and register copies.
    // ------------------------------------------------------------------
    logic [23:0]   pal_mem [PAL_DEPTH];
    logic [23:0]   fade_from;
    logic [23:0]   fade_to;
    int            fade_step;
    int            to_index;
    int            seq_index;
    logic [7:0]    mirror_steps;
    logic [4:0]    mirror_size;
    logic          mirror_mode;

    color_result_t pending_colors[$];
    int            mismatch_count = 0;

    // sender burst bookkeeping
    int            burst_left = 0;

    // long hold-off requests, served by the receiver process
    int            stall_requests = 0;
    int            stall_served   = 0;
    int            hold_left      = 0;
    ready_style_t  ready_style    = READY_ALWAYS;
    int            style_left     = 0;
    int            run_left       = 0;

    palette_color_fader #(
        .PALETTE_DEPTH(PAL_DEPTH)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_entry_index(s_entry_index),
        .s_entry_color(s_entry_color),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_color_index(m_color_index)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic clear_fader_state();
        foreach (pal_mem[i]) pal_mem[i] = '0;
        fade_from    = '0;
        fade_to      = '0;
        fade_step    = 0;
        to_index     = 1;
        seq_index    = 0;
        mirror_steps = pcf_pkg::FADE_STEPS_RESET;
        mirror_size  = '0;
        mirror_mode  = 1'b0;
    endtask

    // one channel of the linear blend; int math truncates toward zero
    function automatic logic [7:0] blend_channel(input logic [7:0] from_c,
                                                 input logic [7:0] to_c,
                                                 input int step, input int total);
        int f;
        int t;
        int q;
        f = from_c;
        t = to_c;
        q = ((t - f) * step) / total;
        return 8'(f + q);
    endfunction

    function automatic int used_size();
        return (mirror_size > PAL_DEPTH) ? PAL_DEPTH : int'(mirror_size);
    endfunction

    // apply one accepted transaction, queue the color it must produce
    task automatic compute_expected_color(input logic [1:0] cmd, input logic [3:0] idx,
                                          input logic [23:0] color);
        int            size;
        int            total;
        int            i;
        color_result_t res;
        size = used_size();
        case (cmd)
            pcf_pkg::CMD_LOAD: begin
                pal_mem[idx] = color;
            end
            pcf_pkg::CMD_RESTART: begin
                fade_step = 0;
                seq_index = 0;
                if (size == 0) begin
                    to_index  = 0;
                    fade_from = '0;
                    fade_to   = '0;
                end else begin
                    to_index  = 1 % size;
                    fade_from = pal_mem[0];
                    fade_to   = pal_mem[to_index];
                end
            end
            pcf_pkg::CMD_TICK: begin
                if (size != 0) begin
                    if (!mirror_mode) begin
                        // step mode: stale index past the size wraps to 0
                        i = (seq_index >= size) ? 0 : seq_index;
                        res.red   = pal_mem[i][23:16];
                        res.green = pal_mem[i][15:8];
                        res.blue  = pal_mem[i][7:0];
                        res.index = 4'(i);
                        seq_index = (i + 1 >= size) ? 0 : i + 1;
                    end else begin
                        total = (mirror_steps == 0) ? 1 : int'(mirror_steps);
                        if (fade_step >= total) begin
                            // fade done: old target becomes the start
                            fade_step = 0;
                            i         = (to_index >= size) ? 0 : to_index;
                            to_index  = (i + 1 >= size) ? 0 : i + 1;
                            fade_from = fade_to;
                            fade_to   = pal_mem[to_index];
                        end
                        res.red   = blend_channel(fade_from[23:16], fade_to[23:16],
                                                  fade_step, total);
                        res.green = blend_channel(fade_from[15:8], fade_to[15:8],
                                                  fade_step, total);
                        res.blue  = blend_channel(fade_from[7:0], fade_to[7:0],
                                                  fade_step, total);
                        res.index = 4'(to_index);
                        fade_step = (fade_step + 1) & 8'hFF;
                    end
                    pending_colors.push_back(res);
                end
            end
            default: ;  // unused command code: no effect
        endcase
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // compare each accepted color transaction with the oldest prediction
    always @(posedge aclk) begin
        color_result_t exp_c;
        if (aresetn && m_valid && m_ready) begin
            if (pending_colors.size() == 0) begin
                report_mismatch($sformatf("unexpected color %02x%02x%02x idx %0d",
                                          m_red, m_green, m_blue, m_color_index));
            end else begin
                exp_c = pending_colors.pop_front();
                if (m_red !== exp_c.red)
                    report_mismatch($sformatf("red %02x, want %02x", m_red, exp_c.red));
                if (m_green !== exp_c.green)
                    report_mismatch($sformatf("green %02x, want %02x",
                                              m_green, exp_c.green));
                if (m_blue !== exp_c.blue)
                    report_mismatch($sformatf("blue %02x, want %02x", m_blue, exp_c.blue));
                if (m_color_index !== exp_c.index)
                    report_mismatch($sformatf("color_index %0d, want %0d",
                                              m_color_index, exp_c.index));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: m_ready style changes every so often; a long hold-off is
    // served whenever the test bumps stall_requests.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (stall_served != stall_requests) begin
            stall_served <= stall_requests;
            hold_left    <= HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else begin
            if (style_left == 0) begin
                ready_style <= ready_style_t'($urandom_range(0, 2));
                style_left  <= $urandom_range(20, 300);
            end else begin
                style_left <= style_left - 1;
            end
            case (ready_style)
                READY_ALWAYS: m_ready <= 1'b1;
                READY_COIN:   m_ready <= 1'($urandom_range(0, 1));
                default: begin
                    // alternating runs of ready and stall of random length
                    if (run_left == 0) begin
                        m_ready  <= ~m_ready;
                        run_left <= $urandom_range(1, 20);
                    end else begin
                        run_left <= run_left - 1;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. All tasks start and end right after a rising edge.
    // ------------------------------------------------------------------

    // offer one transaction; s_valid is left high for back-to-back sends
    task automatic send_item(input logic [1:0] cmd, input logic [3:0] idx,
                             input logic [23:0] color);
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_entry_index <= idx;
        s_entry_color <= color;
        do @(posedge aclk); while (!s_ready);
        compute_expected_color(cmd, idx, color);
    endtask

    // send, then idle the input at random between bursts
    task automatic issue_item(input logic [1:0] cmd, input logic [3:0] idx,
                              input logic [23:0] color);
        int gap;
        send_item(cmd, idx, color);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // stop sending, wait for every predicted color, then let loads and
    // restarts (which give no result) finish
    task automatic settle_block();
        int waited;
        waited  = 0;
        s_valid <= 1'b0;
        while (pending_colors.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            pcf_pkg::REG_FADE_STEPS:   mirror_steps = data;
            pcf_pkg::REG_PALETTE_SIZE: mirror_size  = data[4:0];
            pcf_pkg::REG_FADE_MODE:    mirror_mode  = data[0];
            default: ;
        endcase
    endtask

    // reconfigure only once the block is idle; fade state is kept
    task automatic set_config(input int steps, input int size, input bit mode);
        settle_block();
        write_reg(pcf_pkg::REG_FADE_STEPS, 8'(steps));
        write_reg(pcf_pkg::REG_PALETTE_SIZE, 8'(size));
        write_reg(pcf_pkg::REG_FADE_MODE, {7'd0, mode});
    endtask

    task automatic send_ticks(input int n);
        repeat (n) issue_item(pcf_pkg::CMD_TICK, 4'($urandom), 24'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // palette_size 0 after reset: ticks emit nothing, restart clears, unused code is ignored
    task automatic test_empty_palette();
        issue_item(pcf_pkg::CMD_TICK, 4'd0, 24'h000000);
        issue_item(pcf_pkg::CMD_RESTART, 4'd15, 24'hFFFFFF);
        issue_item(CMD_UNUSED, 4'd15, 24'hFFFFFF);
    endtask

    // extremes first; entry 2 gives odd deltas so truncation shows
    task automatic test_load_extremes();
        issue_item(pcf_pkg::CMD_LOAD, 4'd0, 24'h000000);
        issue_item(pcf_pkg::CMD_LOAD, 4'd1, 24'hFFFFFF);
        issue_item(pcf_pkg::CMD_LOAD, 4'd2, 24'h80017F);
        issue_item(pcf_pkg::CMD_LOAD, 4'd3, 24'h00FF00);
    endtask

    task automatic test_step_sequence();
        set_config(50, 4, 1'b0);
        issue_item(pcf_pkg::CMD_RESTART, 4'd0, 24'h0);
        send_ticks(5);  // wraps past the last entry
    endtask

    task automatic test_fade_sequence();
        // fade length 0 behaves as 1: after the first tick, every tick moves to the next entry
        set_config(0, 3, 1'b1);
        issue_item(pcf_pkg::CMD_RESTART, 4'd0, 24'h0);
        send_ticks(4);
        // three-step fades, falling channels truncate toward zero
        set_config(3, 3, 1'b1);
        issue_item(pcf_pkg::CMD_RESTART, 4'd0, 24'h0);
        send_ticks(7);
    endtask

    // load the rest so no unwritten entry is ever read from here on
    task automatic test_fill_palette();
        for (int i = 4; i < PAL_DEPTH; i++) begin
            issue_item(pcf_pkg::CMD_LOAD, 4'(i),
                       (i == PAL_DEPTH - 1) ? 24'hFFFFFF : 24'($urandom));
        end
    endtask

    // size above the depth clamps to 16; then mode changes keep state and
    // shrinking the size leaves stale indices that must wrap
    task automatic test_size_edges();
        set_config(1, 31, 1'b0);
        issue_item(pcf_pkg::CMD_RESTART, 4'd0, 24'h0);
        send_ticks(18);
        set_config(1, 31, 1'b1);
        send_ticks(4);
        set_config(1, 2, 1'b1);
        send_ticks(3);
        set_config(2, 2, 1'b0);
        send_ticks(3);
    endtask

    // receiver holds off for a long stretch while the sender keeps pushing
    // step-mode ticks back to back, so the block must stall its input
    task automatic test_output_backpressure();
        set_config(4, 16, 1'b0);
        send_item(pcf_pkg::CMD_RESTART, 4'd0, 24'h0);
        stall_requests <= stall_requests + 1;
        repeat (40) send_item(pcf_pkg::CMD_TICK, 4'($urandom), 24'($urandom));
    endtask

    task automatic random_phase();
        int          r;
        logic [1:0]  cmd;
        logic [3:0]  idx;
        logic [23:0] color;
        repeat (PHASE_ITEMS) begin
            r     = $urandom_range(0, 99);
            idx   = 4'($urandom);
            color = 24'($urandom);
            if (r < 72) begin
                cmd = pcf_pkg::CMD_TICK;
            end else if (r < 86) begin
                cmd = pcf_pkg::CMD_LOAD;
                r   = $urandom_range(0, 9);
                if (r == 0) color = 24'h000000;
                else if (r == 1) color = 24'hFFFFFF;
            end else if (r < 94) begin
                cmd = pcf_pkg::CMD_RESTART;
            end else begin
                cmd = CMD_UNUSED;
            end
            issue_item(cmd, idx, color);
        end
    endtask

    // phases with changing registers; no forced restart between phases,
    // so mode switches and size changes hit live fade state
    task automatic test_random_regression();
        int steps;
        int size;
        int r;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p == 0) begin
                steps = 255;
                size  = 16;
            end else begin
                r     = $urandom_range(0, 9);
                steps = (r == 0) ? 0 : (r == 1) ? 255 : (r == 2) ? 1 : $urandom_range(2, 9);
                r     = $urandom_range(0, 9);
                size  = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 16 :
                        (r == 3) ? $urandom_range(17, 31) : $urandom_range(2, 15);
            end
            set_config(steps, size, (p == 0) ? 1'b1 : 1'($urandom_range(0, 1)));
            random_phase();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        clear_fader_state();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_palette();
        test_load_extremes();
        test_step_sequence();
        test_fade_sequence();
        test_fill_palette();
        test_size_edges();
        test_output_backpressure();
        test_random_regression();

        settle_block();
        if (pending_colors.size() != 0)
            report_mismatch($sformatf("%0d predicted colors never came out",
                                      pending_colors.size()));

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog: several times the slowest legal run
    initial begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
